>>> hdl/ttat_pkg.sv
package ttat_pkg;

    // Default table geometry
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TAG_BITS_DEF      = 16;
    localparam int TIME_BITS_DEF     = 24;

    // Fixed field widths
    localparam int REQ_BITS     = 2;
    localparam int ELAPSED_BITS = 16;

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_TICK  = 2'd2;

endpackage

>>> hdl/timed_tag_aging_table_unit.sv
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_req_type i_tag_key i_duration_ms i_elapsed_ms
// result    out        o_out_valid / i_out_stall  o_found o_remaining_ms o_entries_used
//                                                 o_removed_count o_dropped
//
// Add and query: one entry read per cycle from the entry memory, stopping early on a hit,
//   then the result register is loaded once it is free.
// Tick: after the accept, each live entry takes a read state, then an age and write-back
//   state (separate read and write ports); each expired entry that the last entry replaces
//   takes one more state to move it, then the result register is loaded.
// Zero tick, tick on an empty table or unused request code: straight to the result load.
// Reset (synchronous, active low) empties the table; entry memory is not cleared.
// A result waiting under i_out_stall does not block a new request beat; only a second
//   finished result waits until the first is taken.
module timed_tag_aging_table_unit
    import ttat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = TAG_BITS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [REQ_BITS-1:0]                   i_req_type,
    input  logic [TAG_BITS-1:0]                   i_tag_key,
    input  logic [TIME_BITS-1:0]                  i_duration_ms,
    input  logic [ELAPSED_BITS-1:0]               i_elapsed_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_found,
    output logic [TIME_BITS-1:0]                  o_remaining_ms,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]    o_entries_used,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]    o_removed_count,
    output logic                                  o_dropped
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = TAG_BITS + TIME_BITS;
    localparam int SW = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOK = 6'b000010,
        S_TRD  = 6'b000100,
        S_TEV  = 6'b001000,
        S_TMV  = 6'b010000,
        S_PUT  = 6'b100000
    } t_state;

    // Entry memory: {tag, remaining}
    logic [EW-1:0]           r_mem [TABLE_ENTRIES];
    logic [EW-1:0]           r_rdata;
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    logic [EW-1:0]           mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;

    // Control state
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_live, n_live;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;

    // Request and result payload
    logic [REQ_BITS-1:0]     r_req, n_req;
    logic [TAG_BITS-1:0]     r_tag, n_tag;
    logic [TIME_BITS-1:0]    r_dur, n_dur;
    logic [ELAPSED_BITS-1:0] r_elapsed, n_elapsed;
    logic [IW-1:0]           r_rd_idx, n_rd_idx;
    logic [CW-1:0]           r_removed, n_removed;
    logic                    r_res_found, n_res_found;
    logic [TIME_BITS-1:0]    r_res_rem, n_res_rem;
    logic                    r_res_drop, n_res_drop;
    logic                    r_found, n_found;
    logic [TIME_BITS-1:0]    r_rem, n_rem;
    logic [CW-1:0]           r_used, n_used;
    logic [CW-1:0]           r_rmv, n_rmv;
    logic                    r_drop, n_drop;

    // Datapath helpers
    logic [TAG_BITS-1:0]     w_rd_tag;
    logic [TIME_BITS-1:0]    w_rd_time;
    logic [SW-1:0]           w_ext_r, w_ext_e, w_diff;
    logic [TIME_BITS-1:0]    w_aged;
    logic [CW-1:0]           w_cnt_m1, w_live_m1;
    logic [IW-1:0]           w_cur_idx;
    logic                    w_hit;
    logic                    w_load;

    // Entry memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Split read data and age the remaining time with saturation
    assign w_rd_tag  = r_rdata[EW-1:TIME_BITS];
    assign w_rd_time = r_rdata[TIME_BITS-1:0];
    assign w_ext_r   = SW'(w_rd_time);
    assign w_ext_e   = SW'(r_elapsed);
    assign w_diff    = w_ext_r - w_ext_e;
    assign w_aged    = (w_ext_r > w_ext_e) ? w_diff[TIME_BITS-1:0] : '0;

    assign w_cnt_m1  = r_cnt - CW'(1);
    assign w_live_m1 = r_live - CW'(1);
    assign w_cur_idx = w_cnt_m1[IW-1:0];
    assign w_hit     = r_pend && (w_rd_tag == r_tag);
    assign w_load    = !r_out_valid || !i_out_stall;

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_req       = r_req;
        n_tag       = r_tag;
        n_dur       = r_dur;
        n_elapsed   = r_elapsed;
        n_rd_idx    = r_rd_idx;
        n_removed   = r_removed;
        n_res_found = r_res_found;
        n_res_rem   = r_res_rem;
        n_res_drop  = r_res_drop;
        n_found     = r_found;
        n_rem       = r_rem;
        n_used      = r_used;
        n_rmv       = r_rmv;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                // Capture the request beat and pick the walk
                if (i_in_valid) begin
                    n_req       = i_req_type;
                    n_tag       = i_tag_key;
                    n_dur       = i_duration_ms;
                    n_elapsed   = i_elapsed_ms;
                    n_pend      = 1'b0;
                    n_removed   = '0;
                    n_res_found = 1'b0;
                    n_res_rem   = '0;
                    n_res_drop  = 1'b0;
                    n_cnt       = '0;
                    unique case (i_req_type) inside
                        REQ_ADD, REQ_QUERY: begin
                            n_state = S_LOOK;
                        end
                        REQ_TICK: begin
                            n_cnt = r_live;
                            if ((i_elapsed_ms != '0) && (r_live != '0)) begin
                                n_state = S_TRD;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        default: begin
                            n_state = S_PUT;
                        end
                    endcase
                end
            end

            S_LOOK: begin
                // Stream reads up the live entries, compare each in the cycle after its read
                n_pend = 1'b0;
                if (w_hit) begin
                    n_res_found = 1'b1;
                    if (r_req == REQ_ADD) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_rd_idx;
                        mem_wdata = {r_tag, r_dur};
                    end else begin
                        n_res_rem = w_rd_time;
                    end
                    n_state = S_PUT;
                end else if (r_cnt != r_live) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cnt[IW-1:0];
                    n_rd_idx  = r_cnt[IW-1:0];
                    n_pend    = 1'b1;
                    n_cnt     = r_cnt + CW'(1);
                end else if (!r_pend) begin
                    // Miss: an add appends the new tag or drops it when full
                    if (r_req == REQ_ADD) begin
                        if (r_live != FULL) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_live[IW-1:0];
                            mem_wdata = {r_tag, r_dur};
                            n_live    = r_live + CW'(1);
                        end else begin
                            n_res_drop = 1'b1;
                        end
                    end
                    n_state = S_PUT;
                end
            end

            S_TRD: begin
                // Read the entry under the downward scan
                mem_re    = 1'b1;
                mem_raddr = w_cur_idx;
                n_state   = S_TEV;
            end

            S_TEV: begin
                // Age the entry; keep it, drop the last one, or fetch the last one
                if (w_aged != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = w_cur_idx;
                    mem_wdata = {w_rd_tag, w_aged};
                    n_cnt     = w_cnt_m1;
                    n_state   = (r_cnt == CW'(1)) ? S_PUT : S_TRD;
                end else if (r_cnt == r_live) begin
                    n_live    = w_live_m1;
                    n_removed = r_removed + CW'(1);
                    n_cnt     = w_cnt_m1;
                    n_state   = (r_cnt == CW'(1)) ? S_PUT : S_TRD;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = w_live_m1[IW-1:0];
                    n_state   = S_TMV;
                end
            end

            S_TMV: begin
                // Move the last entry, already aged, into the expired slot
                mem_we    = 1'b1;
                mem_waddr = w_cur_idx;
                mem_wdata = r_rdata;
                n_live    = w_live_m1;
                n_removed = r_removed + CW'(1);
                n_cnt     = w_cnt_m1;
                n_state   = (r_cnt == CW'(1)) ? S_PUT : S_TRD;
            end

            S_PUT: begin
                // Load the result register once it is free
                if (w_load) begin
                    n_found     = r_res_found;
                    n_rem       = r_res_rem;
                    n_used      = r_live;
                    n_rmv       = r_removed;
                    n_drop      = r_res_drop;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_tag       <= n_tag;
        r_dur       <= n_dur;
        r_elapsed   <= n_elapsed;
        r_rd_idx    <= n_rd_idx;
        r_removed   <= n_removed;
        r_res_found <= n_res_found;
        r_res_rem   <= n_res_rem;
        r_res_drop  <= n_res_drop;
        r_found     <= n_found;
        r_rem       <= n_rem;
        r_used      <= n_used;
        r_rmv       <= n_rmv;
        r_drop      <= n_drop;
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_remaining_ms  = r_rem;
    assign o_entries_used  = r_used;
    assign o_removed_count = r_rmv;
    assign o_dropped       = r_drop;

    // Checks
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= FULL)
        else $error("live count above table size");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (o_entries_used == FULL) && !o_found)
        else $error("drop flagged with room in the table");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_removed_count == '0) && !o_dropped)
        else $error("hit result carries tick or drop flags");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_PUT))
        else $error("result beat raised outside the result load");

endmodule

>>> tb/timed_tag_aging_table_unit_tb.sv
`timescale 1ns / 1ps

module timed_tag_aging_table_unit_tb;
    import ttat_pkg::*;

    localparam int ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int TAG_W      = TAG_BITS_DEF;
    localparam int TIME_W     = TIME_BITS_DEF;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int POOL_SIZE  = 24;
    localparam int RAND_ITEMS = 1700;
    localparam int CALM_FROM  = 1450;
    localparam int DRAIN_CYC  = 64;
    localparam int STUCK_CYC  = 2000;

    // Spare request code, not named in the package
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] remaining;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  removed;
        logic              dropped;
    } t_answer;

    // Shadow copy of the aging table plus the answers still owed by the block
    class t_aging_table_tracker;
        logic [TAG_W-1:0]  tags [ENTRIES];
        logic [TIME_W-1:0] left_ms [ENTRIES];
        int                live;
        t_answer           pending_answers [$];
        int                mismatches;

        function new();
            live       = 0;
            mismatches = 0;
        endfunction

        function int find_tag(logic [TAG_W-1:0] tag);
            for (int i = 0; i < live; i++) begin
                if (tags[i] == tag) return i;
            end
            return -1;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Apply one accepted request beat and queue the answer it must produce
        task note_request(logic [REQ_BITS-1:0] req, logic [TAG_W-1:0] tag,
                          logic [TIME_W-1:0] dur, logic [ELAPSED_BITS-1:0] elapsed);
            t_answer ans;
            int      idx;
            ans = '0;
            if (req == REQ_ADD) begin
                idx = find_tag(tag);
                if (idx >= 0) begin
                    left_ms[idx] = dur;
                    ans.found    = 1'b1;
                end else if (live < ENTRIES) begin
                    tags[live]    = tag;
                    left_ms[live] = dur;
                    live++;
                end else begin
                    ans.dropped = 1'b1;
                end
            end else if (req == REQ_QUERY) begin
                idx = find_tag(tag);
                if (idx >= 0) begin
                    ans.found     = 1'b1;
                    ans.remaining = left_ms[idx];
                end
            end else if (req == REQ_TICK && elapsed != '0) begin
                // Age every live entry, saturating at zero
                for (int i = 0; i < live; i++) begin
                    left_ms[i] = (left_ms[i] > elapsed) ? left_ms[i] - elapsed : '0;
                end
                // Scan down, fill each expired slot with the last live entry
                for (int i = live - 1; i >= 0; i--) begin
                    if (left_ms[i] == '0) begin
                        tags[i]    = tags[live - 1];
                        left_ms[i] = left_ms[live - 1];
                        live--;
                        ans.removed++;
                    end
                end
            end
            ans.used = CNT_W'(live);
            pending_answers.push_back(ans);
        endtask

        // Compare one accepted result beat against the oldest owed answer
        task check_answer(t_answer got);
            t_answer want;
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %b, want %b", got.found, want.found));
            if (got.remaining !== want.remaining)
                report_mismatch($sformatf("remaining_ms %0d, want %0d",
                                          got.remaining, want.remaining));
            if (got.used !== want.used)
                report_mismatch($sformatf("entries_used %0d, want %0d", got.used, want.used));
            if (got.removed !== want.removed)
                report_mismatch($sformatf("removed_count %0d, want %0d",
                                          got.removed, want.removed));
            if (got.dropped !== want.dropped)
                report_mismatch($sformatf("dropped %b, want %b", got.dropped, want.dropped));
        endtask
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [REQ_BITS-1:0]     i_req_type    = REQ_ADD;
    logic [TAG_W-1:0]        i_tag_key     = '0;
    logic [TIME_W-1:0]       i_duration_ms = '0;
    logic [ELAPSED_BITS-1:0] i_elapsed_ms  = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic                    o_found;
    logic [TIME_W-1:0]       o_remaining_ms;
    logic [CNT_W-1:0]        o_entries_used;
    logic [CNT_W-1:0]        o_removed_count;
    logic                    o_dropped;

    t_aging_table_tracker table_sb = new();

    logic [TAG_W-1:0] tag_pool [POOL_SIZE];
    int               out_stall_pct = 0;
    int               stall_left    = 0;
    bit               calm_tail     = 1'b0;
    int               stuck_cycles  = 0;

    timed_tag_aging_table_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_tag_key       (i_tag_key),
        .i_duration_ms   (i_duration_ms),
        .i_elapsed_ms    (i_elapsed_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_remaining_ms  (o_remaining_ms),
        .o_entries_used  (o_entries_used),
        .o_removed_count (o_removed_count),
        .o_dropped       (o_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel in short random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm_tail && $urandom_range(0, 99) < out_stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= int'($urandom_range(1, 6)) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every result beat taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            table_sb.check_answer('{o_found, o_remaining_ms, o_entries_used,
                                    o_removed_count, o_dropped});
        end
    end

    // Give up when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_CYC) begin
            $display("timed_tag_aging_table_unit_tb failed");
            $finish;
        end
    end

    // Present one request beat and hold it until accepted
    task send_request(logic [REQ_BITS-1:0] req, logic [TAG_W-1:0] tag,
                      logic [TIME_W-1:0] dur, logic [ELAPSED_BITS-1:0] elapsed);
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_tag_key     <= tag;
        i_duration_ms <= dur;
        i_elapsed_ms  <= elapsed;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        table_sb.note_request(req, tag, dur, elapsed);
    endtask

    task hold_off(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int               roll;
        int               in_gap_pct;
        logic [REQ_BITS-1:0]     req;
        logic [TAG_W-1:0]        tag;
        logic [TIME_W-1:0]       dur;
        logic [ELAPSED_BITS-1:0] elapsed;

        in_gap_pct = 0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) tag_pool[k] = TAG_W'($urandom);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty lookups, extremes, refresh, spare code, zero tick
        send_request(REQ_QUERY,  16'h1234, 24'd0,      16'd0);
        send_request(REQ_ADD,    16'h0000, 24'hFFFFFF, 16'd0);
        send_request(REQ_ADD,    16'hFFFF, 24'd0,      16'hFFFF);
        send_request(REQ_QUERY,  16'hFFFF, 24'd7,      16'd0);
        send_request(REQ_QUERY,  16'h0000, 24'd0,      16'd0);
        send_request(REQ_ADD,    16'h0000, 24'd5,      16'd0);
        send_request(REQ_UNUSED, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        send_request(REQ_TICK,   16'hA5A5, 24'hFFFFFF, 16'd0);
        send_request(REQ_TICK,   16'h0000, 24'd0,      16'd1);
        send_request(REQ_QUERY,  16'h0000, 24'd0,      16'd0);
        // Fill the table, then overflow it and refresh an entry while full
        for (int k = 0; k < ENTRIES - 1; k++) begin
            send_request(REQ_ADD, TAG_W'(16'h0100 + k), TIME_W'(40 * (k + 1)), 16'd0);
        end
        send_request(REQ_ADD,    16'hABCD, 24'd100,    16'd0);
        send_request(REQ_ADD,    16'h0100, 24'hFFFFFF, 16'd0);
        send_request(REQ_TICK,   16'hFFFF, 24'd0,      16'hFFFF);

        // Random: mostly pool tags so lookups hit, ticks small enough to age gradually
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) begin
                roll          = $urandom_range(0, 2);
                in_gap_pct    = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
                roll          = $urandom_range(0, 2);
                out_stall_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
            end
            if (n == CALM_FROM) calm_tail = 1'b1;
            if (!calm_tail && $urandom_range(0, 99) < in_gap_pct)
                hold_off($urandom_range(1, 6));

            tag     = TAG_W'($urandom);
            dur     = TIME_W'($urandom);
            elapsed = ELAPSED_BITS'($urandom);
            roll    = $urandom_range(0, 99);
            if (roll < 3) begin
                req = REQ_UNUSED;
            end else if (roll < 48) begin
                req  = REQ_ADD;
                tag  = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
                roll = $urandom_range(0, 99);
                if (roll < 5)       dur = '0;
                else if (roll < 91) dur = TIME_W'($urandom_range(1, 3000));
            end else if (roll < 80) begin
                req = REQ_QUERY;
                if ($urandom_range(0, 9) != 0) tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                req  = REQ_TICK;
                roll = $urandom_range(0, 99);
                if (roll < 10)      elapsed = '0;
                else if (roll < 80) elapsed = ELAPSED_BITS'($urandom_range(1, 400));
            end
            send_request(req, tag, dur, elapsed);
        end
        i_in_valid <= 1'b0;

        // Drain owed answers, then watch for stray beats
        while (table_sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (table_sb.mismatches == 0) begin
            $display("timed_tag_aging_table_unit_tb passed");
        end else begin
            $display("timed_tag_aging_table_unit_tb failed");
        end
        $finish;
    end

endmodule
